// ----- sv/lcsc_pkg.sv -----
package lcsc_pkg;

    localparam int MAX_VALUE = 65535;
    localparam int QUERY_W   = 16;
    localparam int COUNT_W   = 4;
    localparam int ADDR_W    = $clog2(MAX_VALUE + 1);
    localparam int FILL_W    = ADDR_W + 1;
    localparam int ROOT_W    = 6;
    localparam int CUBE_W    = 18;
    localparam int STEP_W    = 3;
    localparam int OP_W      = 3;
    localparam int COND_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 4'd15;

    // sequencer steps
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HEAD   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WRITE  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LOOKUP = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;
    localparam logic [STEP_W-1:0] STEP_RETRY  = 3'd7;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT = 3'd1;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd6;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NONE      = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] COND_NO_ITEM   = 3'd2;
    localparam logic [COND_W-1:0] COND_FILLED    = 3'd3;
    localparam logic [COND_W-1:0] COND_SPECIAL   = 3'd4;
    localparam logic [COND_W-1:0] COND_SCAN_MORE = 3'd5;
    localparam logic [COND_W-1:0] COND_OUT_FREE  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] wr_data;
    } tbl_req_t;

    // control store
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        begin
            case (step)
                STEP_IDLE:   cw = '{OP_ACCEPT, COND_NO_ITEM,   STEP_IDLE};
                STEP_CHECK:  cw = '{OP_NOP,    COND_FILLED,    STEP_LOOKUP};
                STEP_HEAD:   cw = '{OP_HEAD,   COND_SPECIAL,   STEP_CHECK};
                STEP_SCAN:   cw = '{OP_SCAN,   COND_SCAN_MORE, STEP_SCAN};
                STEP_WRITE:  cw = '{OP_WRITE,  COND_ALWAYS,    STEP_CHECK};
                STEP_LOOKUP: cw = '{OP_LOOKUP, COND_NONE,      STEP_EMIT};
                STEP_EMIT:   cw = '{OP_EMIT,   COND_OUT_FREE,  STEP_IDLE};
                default:     cw = '{OP_NOP,    COND_ALWAYS,    STEP_EMIT};
            endcase
            return cw;
        end
    endfunction

    // cubes of small roots; roots past the table never match
    function automatic logic [CUBE_W-1:0] cube_of(input logic [ROOT_W-1:0] r);
        logic [CUBE_W-1:0] c;
        begin
            case (r)
                6'd0:  c = 18'd0;
                6'd1:  c = 18'd1;
                6'd2:  c = 18'd8;
                6'd3:  c = 18'd27;
                6'd4:  c = 18'd64;
                6'd5:  c = 18'd125;
                6'd6:  c = 18'd216;
                6'd7:  c = 18'd343;
                6'd8:  c = 18'd512;
                6'd9:  c = 18'd729;
                6'd10: c = 18'd1000;
                6'd11: c = 18'd1331;
                6'd12: c = 18'd1728;
                6'd13: c = 18'd2197;
                6'd14: c = 18'd2744;
                6'd15: c = 18'd3375;
                6'd16: c = 18'd4096;
                6'd17: c = 18'd4913;
                6'd18: c = 18'd5832;
                6'd19: c = 18'd6859;
                6'd20: c = 18'd8000;
                6'd21: c = 18'd9261;
                6'd22: c = 18'd10648;
                6'd23: c = 18'd12167;
                6'd24: c = 18'd13824;
                6'd25: c = 18'd15625;
                6'd26: c = 18'd17576;
                6'd27: c = 18'd19683;
                6'd28: c = 18'd21952;
                6'd29: c = 18'd24389;
                6'd30: c = 18'd27000;
                6'd31: c = 18'd29791;
                6'd32: c = 18'd32768;
                6'd33: c = 18'd35937;
                6'd34: c = 18'd39304;
                6'd35: c = 18'd42875;
                6'd36: c = 18'd46656;
                6'd37: c = 18'd50653;
                6'd38: c = 18'd54872;
                6'd39: c = 18'd59319;
                6'd40: c = 18'd64000;
                6'd41: c = 18'd68921;
                default: c = '1;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- sv/lcsc_table.sv -----
module lcsc_table (
    input  logic                          clk,
    input  lcsc_pkg::tbl_req_t            req,
    output logic [lcsc_pkg::COUNT_W-1:0]  rd_data
);

    // best count per value, contents undefined until filled
    logic [lcsc_pkg::COUNT_W-1:0] mem [0:lcsc_pkg::MAX_VALUE];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

// ----- sv/least_cube_sum_count_top.sv -----
// least number of positive cubes that sum to a query value
//
// input channel: query_valid / query_stall carrying query_value (16 bits).
// output channel: result_valid / result_stall carrying cube_count (4 bits).
// an item moves on a rising edge where valid is high and stall is low.
//
// one item is worked at a time. a table of best counts is extended in
// ascending order up to the query value and kept for later items. an item
// at or below the largest value seen so far goes from the check step
// straight to the lookup and emit steps. a new entry that is zero or a
// perfect cube is written at the head step; any other is scanned over the
// cubes of roots 1 to r (r the largest cube root not above it, at most
// 40), one table read per cube per cycle, and written at the write step.
//
// reset clears the sequencer, the fill pointer and the root register; no
// clearing pass is needed because only filled entries are ever read.
// while a result is stalled at the output, the next item is still taken
// and worked; it waits at the emit and retry steps till the output frees.
module least_cube_sum_count_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          query_valid,
    output logic                          query_stall,
    input  logic [lcsc_pkg::QUERY_W-1:0]  query_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [lcsc_pkg::COUNT_W-1:0]  cube_count
);

    // sequencer state
    logic [lcsc_pkg::STEP_W-1:0]  step_reg, step_next;
    lcsc_pkg::ctrl_word_t         cw;
    logic                         jump;

    // datapath registers
    logic [lcsc_pkg::ADDR_W-1:0]  n_reg, n_next;
    logic [lcsc_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [lcsc_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [lcsc_pkg::ROOT_W-1:0]  k_reg, k_next;
    logic [lcsc_pkg::COUNT_W-1:0] best_reg, best_next;
    logic                         pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;
    logic [lcsc_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    // datapath terms
    logic [lcsc_pkg::ADDR_W-1:0]  cur_value;
    logic [lcsc_pkg::CUBE_W-1:0]  cur_value_ext;
    logic [lcsc_pkg::CUBE_W-1:0]  next_root_cube;
    logic [lcsc_pkg::CUBE_W-1:0]  k_cube;
    logic                         is_special;
    logic                         scan_more;
    logic                         filled;
    logic                         out_free;
    logic [lcsc_pkg::COUNT_W-1:0] cand;
    logic [lcsc_pkg::ADDR_W-1:0]  query_clamped;

    lcsc_pkg::tbl_req_t           tbl_req;
    logic [lcsc_pkg::COUNT_W-1:0] tbl_rd_data;

    assign cw = lcsc_pkg::ucode(step_reg);

    // value being filled is always below the table size here
    assign cur_value      = fill_reg[lcsc_pkg::ADDR_W-1:0];
    assign cur_value_ext  = lcsc_pkg::CUBE_W'(cur_value);
    assign next_root_cube = lcsc_pkg::cube_of(root_reg + 6'd1);
    assign k_cube         = lcsc_pkg::cube_of(k_reg);

    // zero entry or a perfect cube is settled at the head step
    assign is_special = (cur_value == '0) || (next_root_cube == cur_value_ext);
    // another cube still fits under the value
    assign scan_more  = (k_reg <= root_reg) && (k_cube <= cur_value_ext);
    assign filled     = fill_reg > lcsc_pkg::FILL_W'(n_reg);
    assign out_free   = !out_valid_reg || !result_stall;

    // candidate from the entry read in the previous scan cycle, saturated
    assign cand = (tbl_rd_data == lcsc_pkg::COUNT_CAP) ? lcsc_pkg::COUNT_CAP
                                                       : tbl_rd_data + 4'd1;

    assign query_clamped = (32'(query_value) > lcsc_pkg::MAX_VALUE)
                         ? lcsc_pkg::ADDR_W'(lcsc_pkg::MAX_VALUE)
                         : lcsc_pkg::ADDR_W'(query_value);

    // branch unit
    always_comb
    begin
        case (cw.cond)
            lcsc_pkg::COND_NONE:      jump = 1'b0;
            lcsc_pkg::COND_ALWAYS:    jump = 1'b1;
            lcsc_pkg::COND_NO_ITEM:   jump = !query_valid;
            lcsc_pkg::COND_FILLED:    jump = filled;
            lcsc_pkg::COND_SPECIAL:   jump = is_special;
            lcsc_pkg::COND_SCAN_MORE: jump = scan_more;
            lcsc_pkg::COND_OUT_FREE:  jump = out_free;
            default:                  jump = 1'b0;
        endcase
        step_next = jump ? cw.target : step_reg + 3'd1;
    end

    // input is taken only at the idle step
    assign query_stall = (step_reg != lcsc_pkg::STEP_IDLE);

    // datapath driven by the control word
    always_comb
    begin
        n_next         = n_reg;
        fill_next      = fill_reg;
        root_next      = root_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        pend_next      = 1'b0;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && result_stall;
        tbl_req        = '{wr_en: 1'b0, rd_en: 1'b0, addr: cur_value, wr_data: '0};

        case (cw.op)
            lcsc_pkg::OP_ACCEPT:
            begin
                if (query_valid)
                begin
                    n_next = query_clamped;
                end
            end
            lcsc_pkg::OP_HEAD:
            begin
                best_next = lcsc_pkg::COUNT_CAP;
                k_next    = 6'd1;
                if (cur_value == '0)
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_data = '0;
                    fill_next       = fill_reg + 17'd1;
                end
                else if (next_root_cube == cur_value_ext)
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_data = 4'd1;
                    root_next       = root_reg + 6'd1;
                    fill_next       = fill_reg + 17'd1;
                end
            end
            lcsc_pkg::OP_SCAN:
            begin
                // read for this cube overlaps the compare of the last one
                tbl_req.rd_en = scan_more;
                tbl_req.addr  = cur_value - k_cube[lcsc_pkg::ADDR_W-1:0];
                pend_next     = scan_more;
                k_next        = k_reg + 6'd1;
                if (pend_reg && (cand < best_reg))
                begin
                    best_next = cand;
                end
            end
            lcsc_pkg::OP_WRITE:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_data = best_reg;
                fill_next       = fill_reg + 17'd1;
            end
            lcsc_pkg::OP_LOOKUP:
            begin
                tbl_req.rd_en = 1'b1;
                tbl_req.addr  = n_reg;
            end
            lcsc_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_count_next = tbl_rd_data;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= lcsc_pkg::STEP_IDLE;
            fill_reg      <= '0;
            root_reg      <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            fill_reg      <= fill_next;
            root_reg      <= root_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        best_reg      <= best_next;
        out_count_reg <= out_count_next;
    end

    lcsc_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    assign result_valid = out_valid_reg;
    assign cube_count   = out_count_reg;

endmodule

// ----- sv/lcsc_checker.sv -----
module lcsc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          query_valid,
    input  logic                          query_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [lcsc_pkg::COUNT_W-1:0]  cube_count
);

    // a held result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result dropped");

    // every value is a sum of at most nine cubes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> cube_count <= 4'd9)
        else $error("cube count out of range");

    // one item at a time: busy right after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && !query_stall |=> query_stall)
        else $error("second item taken back to back");

    // a new result only appears while an item is in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(query_stall))
        else $error("result without an item in work");

endmodule

bind least_cube_sum_count_top lcsc_checker u_lcsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cube_count   (cube_count)
);
